// ===== hw/rtl/dstrc_pkg.sv =====
// Package for the daylight saving time rule checker.
// Holds rule codes, month constants, the per-item plan struct and calendar tables.
// No dependencies; imported by dstrc_rule_decode and dst_region_rule_check.
package dstrc_pkg;

    typedef enum logic [2:0] {
        RULE_US_CA = 3'd0,
        RULE_UK_EU = 3'd1,
        RULE_AUS   = 3'd2,
        RULE_NZ    = 3'd3,
        RULE_BRA   = 3'd4
    } rule_t;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // Year offset of one full 400-year Gregorian cycle keeps every term positive.
    localparam logic [12:0] YEAR_CYCLE = 13'd400;

    // floor(y / 100) == (y * RECIP_100) >> SHIFT_100 for every y below 43699.
    localparam logic [25:0] RECIP_100 = 26'd5243;
    localparam int          SHIFT_100 = 19;

    // (s * RECIP_7) >> SHIFT_7 underestimates s / 7 by at most one for s < 512.
    localparam logic [14:0] RECIP_7 = 15'd73;
    localparam int          SHIFT_7 = 9;

    // What one item needs: either a fixed answer or a compare against a Sunday.
    typedef struct packed {
        logic       fixed;      // answer does not depend on the day
        logic       fixed_val;  // the answer when fixed
        logic       use_last;   // compare against the last Sunday of the month
        logic       ge;         // active when day >= Sunday, else when day < Sunday
        logic [1:0] nth_ofs;    // weeks after the first Sunday (0, 1 or 2)
    } plan_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Zeller month term floor(13 * (m + 1) / 5) for March = 3 .. February = 14.
    function automatic logic [5:0] month_term(input logic [3:0] m);
        logic [5:0] t;
        unique case (m)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/dstrc_rule_decode.sv =====
// Region rule decoder for the daylight saving time rule checker.
// Maps the selected rule and the month to a fixed answer or a Sunday compare.
// Depends on dstrc_pkg.
module dstrc_rule_decode (
    input  logic [2:0]      rule,
    input  logic [3:0]      month,
    output dstrc_pkg::plan_t plan
);
    import dstrc_pkg::*;

    always_comb
    begin
        plan = '0;
        if (month < MON_JAN || month > MON_DEC)
        begin
            plan.fixed     = 1'b1;
            plan.fixed_val = 1'b0;
        end
        else
        begin
            unique case (rule_t'(rule))
                RULE_US_CA:
                begin
                    if (month == MON_MAR)
                    begin
                        plan.ge      = 1'b1;
                        plan.nth_ofs = 2'd1;
                    end
                    else if (month == MON_NOV)
                    begin
                        plan.ge = 1'b0;
                    end
                    else
                    begin
                        plan.fixed     = 1'b1;
                        plan.fixed_val = (month > MON_MAR) && (month < MON_NOV);
                    end
                end
                RULE_UK_EU:
                begin
                    if (month == MON_MAR)
                    begin
                        plan.ge       = 1'b1;
                        plan.use_last = 1'b1;
                    end
                    else if (month == MON_OCT)
                    begin
                        plan.use_last = 1'b1;
                    end
                    else
                    begin
                        plan.fixed     = 1'b1;
                        plan.fixed_val = (month > MON_MAR) && (month < MON_OCT);
                    end
                end
                RULE_AUS:
                begin
                    if (month == MON_OCT)
                    begin
                        plan.ge = 1'b1;
                    end
                    else if (month == MON_APR)
                    begin
                        plan.ge = 1'b0;
                    end
                    else
                    begin
                        plan.fixed     = 1'b1;
                        plan.fixed_val = (month > MON_OCT) || (month < MON_APR);
                    end
                end
                RULE_NZ:
                begin
                    if (month == MON_SEP)
                    begin
                        plan.ge       = 1'b1;
                        plan.use_last = 1'b1;
                    end
                    else if (month == MON_APR)
                    begin
                        plan.ge = 1'b0;
                    end
                    else
                    begin
                        plan.fixed     = 1'b1;
                        plan.fixed_val = (month > MON_SEP) || (month < MON_APR);
                    end
                end
                RULE_BRA:
                begin
                    if (month == MON_OCT)
                    begin
                        plan.ge      = 1'b1;
                        plan.nth_ofs = 2'd2;
                    end
                    else if (month == MON_FEB)
                    begin
                        plan.nth_ofs = 2'd2;
                    end
                    else
                    begin
                        plan.fixed     = 1'b1;
                        plan.fixed_val = (month > MON_OCT) || (month < MON_FEB);
                    end
                end
                default:
                begin
                    plan.fixed     = 1'b1;
                    plan.fixed_val = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/dst_region_rule_check.sv =====
// Top level of the daylight saving time rule checker: a five-stage pipeline.
// Depends on dstrc_pkg and dstrc_rule_decode.
//
// Usage:
// The slave stream takes one date per word: year, month and day. The master
// stream returns one word per date with dst_active in bit 0, in the same order.
// The region rule (0 USA/Canada, 1 UK/EU, 2 Australia, 3 New Zealand,
// 4 Brazil, other codes never active) is written through cfg_wr_en and
// cfg_wr_data; it is sampled as a date enters, so write it only while idle.
// Throughput is one date per cycle while the master side is ready. The
// accepting edge loads stage 1, and the word then passes in order through
// the remaining stages to tvalid on the master side:
//   1. rule decode, year shift, reference day and month term,
//   2. century by reciprocal multiply,
//   3. year of century and the Zeller sum,
//   4. weekday by reciprocal multiply and one correction,
//   5. switching Sunday, day compare, into the output register.
// Each stage moves when it is empty or the next one moves, so bubbles close up
// under a stall and nothing is dropped or repeated; s_axis_tready falls only
// when every stage holds a word and the master side is not ready.
// Reset clears all valid bits and sets the rule to USA/Canada.
// Only the boundary months need a Sunday; the last-Sunday rules use March,
// September and October, so February length and leap years never matter.
module dst_region_rule_check (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: region rule.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    // Slave stream. tdata: [11:0] year, [15:12] month, [20:16] day, [23:21] zero.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    // Master stream. tdata: [0] dst_active, [7:1] zero.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata
);
    import dstrc_pkg::*;

    logic [2:0] region_rule_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            region_rule_reg <= RULE_US_CA;
        else if (cfg_wr_en)
            region_rule_reg <= cfg_wr_data;
    end

    // Stage enables, from the output back to the input.
    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign en5 = !v5_reg || m_axis_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // ---------------- Stage 1: decode and year shift ----------------
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    plan_t       plan_next;
    logic        early_month;
    logic [12:0] yadj_next;
    logic [3:0]  madj_next;
    logic [4:0]  dref_next;

    assign in_year  = s_axis_tdata[11:0];
    assign in_month = s_axis_tdata[15:12];
    assign in_day   = s_axis_tdata[20:16];

    dstrc_rule_decode u_decode (
        .rule  (region_rule_reg),
        .month (in_month),
        .plan  (plan_next)
    );

    // January and February count as months 13 and 14 of the year before.
    assign early_month = in_month < MON_MAR;
    assign yadj_next   = {1'b0, in_year} + YEAR_CYCLE - {12'd0, early_month};
    assign madj_next   = early_month ? in_month + 4'd12 : in_month;
    // The weekday is taken of day 1, or of the last day for a last-Sunday rule.
    assign dref_next   = plan_next.use_last ? month_len(in_month) : 5'd1;

    plan_t       plan1_reg;
    logic [12:0] yadj1_reg;
    logic [5:0]  mterm1_reg;
    logic [4:0]  dref1_reg;
    logic [4:0]  day1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            plan1_reg  <= plan_next;
            yadj1_reg  <= yadj_next;
            mterm1_reg <= month_term(madj_next);
            dref1_reg  <= dref_next;
            day1_reg   <= in_day;
        end
    end

    // ---------------- Stage 2: century ----------------
    logic [25:0] cent_prod;
    logic [5:0]  cent_next;

    assign cent_prod = {13'd0, yadj1_reg} * RECIP_100;
    assign cent_next = cent_prod[SHIFT_100 +: 6];

    plan_t       plan2_reg;
    logic [12:0] yadj2_reg;
    logic [5:0]  mterm2_reg;
    logic [4:0]  dref2_reg;
    logic [4:0]  day2_reg;
    logic [5:0]  cent2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            plan2_reg  <= plan1_reg;
            yadj2_reg  <= yadj1_reg;
            mterm2_reg <= mterm1_reg;
            dref2_reg  <= dref1_reg;
            day2_reg   <= day1_reg;
            cent2_reg  <= cent_next;
        end
    end

    // ---------------- Stage 3: Zeller sum ----------------
    logic [12:0] yoc_wide;
    logic [6:0]  yoc;
    logic [8:0]  zsum_next;

    assign yoc_wide  = yadj2_reg - 13'(cent2_reg) * 13'd100;
    assign yoc       = yoc_wide[6:0];
    // Five times the century stands in for minus two times it, modulo seven.
    assign zsum_next = 9'(dref2_reg) + 9'(mterm2_reg) + 9'(yoc) + 9'(yoc >> 2)
                     + 9'(cent2_reg >> 2) + 9'(cent2_reg) * 9'd5;

    plan_t      plan3_reg;
    logic [4:0] dref3_reg;
    logic [4:0] day3_reg;
    logic [8:0] zsum3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            plan3_reg <= plan2_reg;
            dref3_reg <= dref2_reg;
            day3_reg  <= day2_reg;
            zsum3_reg <= zsum_next;
        end
    end

    // ---------------- Stage 4: weekday ----------------
    logic [14:0] q7_prod;
    logic [5:0]  q7;
    logic [8:0]  rem_wide;
    logic [3:0]  rem_raw;
    logic [2:0]  zel_h;
    logic [2:0]  wday_next;

    assign q7_prod  = {6'd0, zsum3_reg} * RECIP_7;
    assign q7       = q7_prod[SHIFT_7 +: 6];
    assign rem_wide = zsum3_reg - 9'(q7) * 9'd7;
    assign rem_raw  = rem_wide[3:0];
    assign zel_h    = (rem_raw >= 4'd7) ? 3'(rem_raw - 4'd7) : rem_raw[2:0];
    // Zeller counts from Saturday; shift so that Sunday is zero.
    assign wday_next = (zel_h == 3'd0) ? 3'd6 : zel_h - 3'd1;

    plan_t      plan4_reg;
    logic [4:0] dref4_reg;
    logic [4:0] day4_reg;
    logic [2:0] wday4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            plan4_reg <= plan3_reg;
            dref4_reg <= dref3_reg;
            day4_reg  <= day3_reg;
            wday4_reg <= wday_next;
        end
    end

    // ---------------- Stage 5: Sunday and compare ----------------
    logic [4:0] first_sun;
    logic [4:0] sunday;
    logic       day_ok;
    logic       active_next;

    assign first_sun = (wday4_reg == 3'd0) ? 5'd1 : 5'd8 - 5'(wday4_reg);
    assign sunday    = plan4_reg.use_last ? dref4_reg - 5'(wday4_reg)
                                          : first_sun + 5'(plan4_reg.nth_ofs) * 5'd7;
    assign day_ok    = plan4_reg.ge ? (day4_reg >= sunday) : (day4_reg < sunday);
    assign active_next = plan4_reg.fixed ? plan4_reg.fixed_val : day_ok;

    logic active5_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
            active5_reg <= active_next;
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = {7'd0, active5_reg};

`ifndef ASSERT_OFF
    // With the output stage empty, nothing upstream can hold the input off.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

    // An accepted word lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted word lost at stage 1");

    // A word leaving stage 4 reaches the output register.
    a_stage4_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && en5) |=> m_axis_tvalid)
        else $error("word lost between stage 4 and output");
`endif

endmodule
